>>> hdl/lpp_pkg.sv
// Shared types, constants and functions for the LRU directory with probabilistic promotion.
`default_nettype none
package lpp_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int RAND_BITS      = 32;
  localparam int PERIOD_BITS    = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 32;
  // remainder bits resolved per cycle by the modulo unit
  localparam int MOD_BITS_PER_CYCLE = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PROMOTE_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANDOM_SEED    = 1'b1;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd2;
  localparam logic [RAND_BITS-1:0]   SEED_RESET   = 32'd1;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_PROMOTE,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } mod_status_t;

  // one xorshift32 step
  function automatic logic [RAND_BITS-1:0] next_random(input logic [RAND_BITS-1:0] x);
    logic [RAND_BITS-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lpp_cell.sv
// One directory cell: a key slot in the recency-ordered chain.
`default_nettype none
module lpp_cell #(
  parameter int KEY_BITS = lpp_pkg::DEF_KEY_BITS
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire lpp_pkg::cell_cmd_t cmd,
  input  wire                     capture,
  input  wire  [KEY_BITS-1:0]     cmp_key,
  input  wire  [KEY_BITS-1:0]     prev_key,
  input  wire                     prev_valid,
  input  wire  [KEY_BITS-1:0]     next_key,
  input  wire                     next_valid,
  input  wire                     seen_in,
  output logic                    seen_out,
  output logic [KEY_BITS-1:0]     key_q,
  output logic                    valid_q
);

  logic match;
  logic take_prev;
  logic take_next;

  // seen_in: the requested key sits in a more recent cell
  assign seen_out = seen_in | match;

  always_comb begin
    take_prev = 1'b0;
    take_next = 1'b0;
    case (cmd)
      lpp_pkg::CMD_INSERT:  take_prev = 1'b1;
      lpp_pkg::CMD_PROMOTE: take_prev = !seen_in;
      lpp_pkg::CMD_REMOVE:  take_next = seen_out;
      default: begin
        take_prev = 1'b0;
        take_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      match   <= 1'b0;
    end else begin
      if (capture) begin
        match <= valid_q && (key_q == cmp_key);
      end
      if (take_prev) begin
        valid_q <= prev_valid;
      end else if (take_next) begin
        valid_q <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_prev) begin
      key_q <= prev_key;
    end else if (take_next) begin
      key_q <= next_key;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lpp_mod.sv
// Multi-cycle remainder unit: dividend modulo period, MOD_BITS_PER_CYCLE dividend bits per cycle.
`default_nettype none
module lpp_mod (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire  [lpp_pkg::RAND_BITS-1:0]     dividend,
  input  wire  [lpp_pkg::PERIOD_BITS-1:0]   divisor,
  output lpp_pkg::mod_status_t              status
);

  localparam int NB    = lpp_pkg::RAND_BITS;
  localparam int PB    = lpp_pkg::PERIOD_BITS;
  localparam int BPC   = lpp_pkg::MOD_BITS_PER_CYCLE;
  localparam int STEPS = NB / BPC;
  localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                busy;
  logic [CNT_BITS-1:0] count;
  logic [NB-1:0]       num;
  logic [PB-1:0]       den;
  logic [PB-1:0]       rem;
  logic [NB-1:0]       num_next;
  logic [PB-1:0]       rem_next;
  logic [PB:0]         trial;

  always_comb begin
    rem_next = rem;
    num_next = num;
    trial    = '0;
    for (int k = 0; k < BPC; k++) begin
      trial    = {rem_next, num_next[NB-1]};
      num_next = num_next << 1;
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
      end
      rem_next = trial[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_BITS'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      // a zero period behaves as one
      den <= (divisor == '0) ? PB'(1) : divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign status.busy     = busy;
  assign status.rem_zero = (rem == '0);

endmodule
`default_nettype wire

>>> hdl/lru_probabilistic_promotion.sv
// Top level: LRU directory with probabilistic promotion on hits.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid / in_ready    | op, key
//  out     | output    | out_valid / out_ready  | hit, promoted, evicted, evicted_key
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A transaction is taken in S_IDLE, its key compared in every cell in S_LOOKUP, and
// the chain shifted with the result registered in S_UPDATE; the next request is taken
// only once the sequencer is back in S_IDLE. The next draw's remainder is worked out
// ahead of time by the modulo unit; after reset, a config write or a hit that advances
// the generator, in_ready stays low until it is done.
// A result held by a stalled out_ready blocks the chain update of the following request.
// Reset is synchronous and empties the directory at once; cfg_ready is always high.
`default_nettype none
module lru_probabilistic_promotion #(
  parameter int ENTRIES  = lpp_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lpp_pkg::DEF_KEY_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  op,
  input  wire  [KEY_BITS-1:0]                  key,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 hit,
  output logic                                 promoted,
  output logic                                 evicted,
  output logic [KEY_BITS-1:0]                  evicted_key,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [lpp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [lpp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t                             state;
  logic                               req_op;
  logic [KEY_BITS-1:0]                req_key;
  logic [lpp_pkg::PERIOD_BITS-1:0]    promote_period;
  logic [lpp_pkg::RAND_BITS-1:0]      random_state;
  logic                               stale;
  logic                               cfg_wr;
  logic                               mod_start;
  logic                               advance;
  logic                               found;
  logic                               do_promote;
  lpp_pkg::cell_cmd_t                 cmd;
  lpp_pkg::mod_status_t               mod_status;

  logic [KEY_BITS-1:0] cell_key   [ENTRIES];
  logic                cell_valid [ENTRIES];
  logic [ENTRIES:0]    seen;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE) && !stale && !mod_status.busy;
  assign mod_start = stale && !mod_status.busy;

  assign found      = seen[ENTRIES];
  assign advance    = (state == S_UPDATE) && !(out_valid && !out_ready);
  assign do_promote = mod_status.rem_zero;

  always_comb begin
    cmd = lpp_pkg::CMD_HOLD;
    if (advance) begin
      if (req_op) begin
        cmd = found ? lpp_pkg::CMD_REMOVE : lpp_pkg::CMD_HOLD;
      end else if (found) begin
        cmd = do_promote ? lpp_pkg::CMD_PROMOTE : lpp_pkg::CMD_HOLD;
      end else begin
        cmd = lpp_pkg::CMD_INSERT;
      end
    end
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] pk;
    logic                pv;
    logic [KEY_BITS-1:0] nk;
    logic                nv;

    // the head takes the requested key; the tail pulls in an empty slot
    if (i == 0) begin : g_head
      assign pk = req_key;
      assign pv = 1'b1;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pv = cell_valid[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign nk = '0;
      assign nv = 1'b0;
    end else begin : g_body
      assign nk = cell_key[i+1];
      assign nv = cell_valid[i+1];
    end

    lpp_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .capture    (state == S_LOOKUP),
      .cmp_key    (req_key),
      .prev_key   (pk),
      .prev_valid (pv),
      .next_key   (nk),
      .next_valid (nv),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .key_q      (cell_key[i]),
      .valid_q    (cell_valid[i])
    );
  end

  lpp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (lpp_pkg::next_random(random_state)),
    .divisor  (promote_period),
    .status   (mod_status)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= op;
      req_key <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      promote_period <= lpp_pkg::PERIOD_RESET;
      random_state   <= lpp_pkg::SEED_RESET;
      stale          <= 1'b1;
    end else begin
      if (advance && !req_op && found) begin
        random_state <= lpp_pkg::next_random(random_state);
      end
      if (cfg_wr) begin
        case (cfg_index)
          lpp_pkg::REG_PROMOTE_PERIOD: begin
            promote_period <= cfg_data[lpp_pkg::PERIOD_BITS-1:0];
          end
          lpp_pkg::REG_RANDOM_SEED: begin
            random_state <= (cfg_data == '0) ? lpp_pkg::SEED_RESET
                                             : cfg_data[lpp_pkg::RAND_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_wr || (advance && !req_op && found)) begin
        stale <= 1'b1;
      end else if (mod_start) begin
        stale <= 1'b0;
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (advance) begin
            state       <= S_IDLE;
            out_valid   <= 1'b1;
            hit         <= found;
            promoted    <= !req_op && found && do_promote;
            evicted     <= !req_op && !found && cell_valid[ENTRIES-1];
            evicted_key <= (!req_op && !found && cell_valid[ENTRIES-1])
                           ? cell_key[ENTRIES-1] : '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
